// ----- hdl/lcc_pkg.sv -----
// shared types, constants and digit helpers for the luhn card number checker
// no dependencies; used by lcc_accum and luhn_card_number_checker_top

package lcc_pkg;

    localparam int DIGIT_W  = 4;
    localparam int LEN_W    = 5;
    localparam int BRAND_W  = 2;
    localparam int SUM_W    = 4;

    // default upper bound of the digit count
    localparam int MAX_LENGTH_DEF = 31;
    // largest count the length field can hold
    localparam int LEN_FIELD_MAX  = (1 << LEN_W) - 1;

    localparam logic [BRAND_W-1:0] BRAND_NONE       = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_VISA       = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_MASTERCARD = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_AMEX       = 2'd3;

    localparam logic [LEN_W-1:0] LEN_VISA_SHORT = 5'd13;
    localparam logic [LEN_W-1:0] LEN_STD        = 5'd16;
    localparam logic [LEN_W-1:0] LEN_AMEX       = 5'd15;

    localparam logic [DIGIT_W-1:0] LEAD_VISA   = 4'd4;
    localparam logic [DIGIT_W-1:0] LEAD_MC     = 4'd5;
    localparam logic [DIGIT_W-1:0] LEAD_AMEX   = 4'd3;
    localparam logic [DIGIT_W-1:0] MC_SEC_LO   = 4'd1;
    localparam logic [DIGIT_W-1:0] MC_SEC_HI   = 4'd5;
    localparam logic [DIGIT_W-1:0] AMEX_SEC_A  = 4'd4;
    localparam logic [DIGIT_W-1:0] AMEX_SEC_B  = 4'd7;

    typedef struct packed {
        logic [BRAND_W-1:0] brand;
        logic               luhn_ok;
        logic [LEN_W-1:0]   length;
    } t_result;

    // digit sum of twice the code, for every 4-bit code
    function automatic logic [SUM_W-1:0] doubled_value(input logic [DIGIT_W-1:0] d);
        logic [SUM_W-1:0] v;
        case (d)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd2;
            4'd2:    v = 4'd4;
            4'd3:    v = 4'd6;
            4'd4:    v = 4'd8;
            4'd5:    v = 4'd1;
            4'd6:    v = 4'd3;
            4'd7:    v = 4'd5;
            4'd8:    v = 4'd7;
            4'd9:    v = 4'd9;
            4'd10:   v = 4'd2;
            4'd11:   v = 4'd4;
            4'd12:   v = 4'd6;
            4'd13:   v = 4'd8;
            4'd14:   v = 4'd10;
            4'd15:   v = 4'd3;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // (sum + addend) mod 10, sum below 10 and addend below 16
    function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] s,
                                                  input logic [SUM_W-1:0] a);
        logic [SUM_W:0] t;
        logic [SUM_W:0] r;
        t = {1'b0, s} + {1'b0, a};
        if (t >= 5'd20) begin
            r = t - 5'd20;
        end else if (t >= 5'd10) begin
            r = t - 5'd10;
        end else begin
            r = t;
        end
        return r[SUM_W-1:0];
    endfunction

    function automatic logic [BRAND_W-1:0] brand_of(input logic [DIGIT_W-1:0] lead,
                                                   input logic [DIGIT_W-1:0] second,
                                                   input logic [LEN_W-1:0]   len);
        logic [BRAND_W-1:0] b;
        b = BRAND_NONE;
        if (lead == LEAD_VISA && (len == LEN_VISA_SHORT || len == LEN_STD)) begin
            b = BRAND_VISA;
        end else if (lead == LEAD_MC && second >= MC_SEC_LO && second <= MC_SEC_HI
                     && len == LEN_STD) begin
            b = BRAND_MASTERCARD;
        end else if (lead == LEAD_AMEX && (second == AMEX_SEC_A || second == AMEX_SEC_B)
                     && len == LEN_AMEX) begin
            b = BRAND_AMEX;
        end
        return b;
    endfunction

endpackage

// ----- hdl/luhn_card_number_checker_top.sv -----
// top level of the luhn card number checker: input register, accumulator, result register
// depends on lcc_pkg and lcc_accum
//
//  channel | ports                                   | dir | payload
//  --------+-----------------------------------------+-----+------------------------
//  in      | i_in_valid  o_in_stall                  | in  | i_digit, i_last_digit
//  out     | o_out_valid i_out_stall                 | out | o_brand, o_luhn_ok, o_length
//
// one digit word per cycle while o_in_stall is low; after its last digit is taken, a result
// passes the input register, then the result register. the accumulator step is the only loop.
// synchronous active-low reset empties both registers and clears the running sums.
// a stalled result holds the input register only when it carries another last digit.

module luhn_card_number_checker_top #(
    parameter int MAX_LENGTH = lcc_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lcc_pkg::DIGIT_W-1:0]   i_digit,
    input  logic                          i_last_digit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lcc_pkg::BRAND_W-1:0]   o_brand,
    output logic                          o_luhn_ok,
    output logic [lcc_pkg::LEN_W-1:0]     o_length
);
    import lcc_pkg::*;

    logic               r_in_valid;
    logic [DIGIT_W-1:0] r_digit;
    logic               r_last;
    logic               r_out_valid;
    t_result            r_out;
    t_result            step_result;
    logic               out_free;
    logic               step;
    logic               n_in_valid;
    logic               n_out_valid;

    assign out_free    = !r_out_valid || !i_out_stall;
    // a non-final digit never needs the result register
    assign step        = r_in_valid && (!r_last || out_free);
    assign o_in_stall  = r_in_valid && !step;
    assign n_in_valid  = i_in_valid || (r_in_valid && !step);
    assign n_out_valid = (step && r_last) || (r_out_valid && i_out_stall);

    lcc_accum #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_digit  (r_digit),
        .i_last   (r_last),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_digit <= i_digit;
            r_last  <= i_last_digit;
        end
        if (step && r_last) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_brand     = r_out.brand;
    assign o_luhn_ok   = r_out.luhn_ok;
    assign o_length    = r_out.length;

endmodule

// ----- hdl/lcc_accum.sv -----
// running luhn sums, digit count and prefix capture for one card number
// depends on lcc_pkg; result is combinational from the word being stepped in

module lcc_accum #(
    parameter int MAX_LENGTH = lcc_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [lcc_pkg::DIGIT_W-1:0]   i_digit,
    input  logic                          i_last,
    output lcc_pkg::t_result              o_result
);
    import lcc_pkg::*;

    localparam int COUNT_CAP_I = (MAX_LENGTH > LEN_FIELD_MAX) ? LEN_FIELD_MAX : MAX_LENGTH;
    localparam logic [LEN_W-1:0] COUNT_CAP = LEN_W'(COUNT_CAP_I);

    logic [SUM_W-1:0]   r_sum_plain,   n_sum_plain;
    logic [SUM_W-1:0]   r_sum_doubled, n_sum_doubled;
    logic [LEN_W-1:0]   r_count,       n_count;
    logic [DIGIT_W-1:0] r_lead,        n_lead;
    logic [DIGIT_W-1:0] r_second,      n_second;

    always_comb begin
        // sums swap roles with every new digit
        n_sum_plain   = add_mod10(r_sum_doubled, i_digit);
        n_sum_doubled = add_mod10(r_sum_plain, doubled_value(i_digit));
        n_lead        = (r_count == '0) ? i_digit : r_lead;
        n_second      = (r_count == LEN_W'(1)) ? i_digit : r_second;
        n_count       = (r_count < COUNT_CAP) ? r_count + LEN_W'(1) : r_count;
    end

    always_comb begin
        o_result.length  = n_count;
        o_result.luhn_ok = (n_sum_plain == '0);
        o_result.brand   = (n_sum_plain == '0) ? brand_of(n_lead, n_second, n_count)
                                               : BRAND_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_plain   <= '0;
            r_sum_doubled <= '0;
            r_count       <= '0;
            r_lead        <= '0;
            r_second      <= '0;
        end else if (i_step) begin
            if (i_last) begin
                // number complete, start over
                r_sum_plain   <= '0;
                r_sum_doubled <= '0;
                r_count       <= '0;
                r_lead        <= '0;
                r_second      <= '0;
            end else begin
                r_sum_plain   <= n_sum_plain;
                r_sum_doubled <= n_sum_doubled;
                r_count       <= n_count;
                r_lead        <= n_lead;
                r_second      <= n_second;
            end
        end
    end

endmodule
